### rtl/hse_pkg.sv
// Shared types, constants and helper functions of the hall odometry and speed estimator.
package hse_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STOP_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_STEP_THRESH  = 2'd1;
    localparam logic [1:0] CFG_ODO_MODULUS  = 2'd2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [15:0] STOP_TIMEOUT_RST = 16'd32000;
    localparam logic [5:0]  STEP_THRESH_RST  = 6'd18;
    localparam logic [13:0] ODO_MODULUS_RST  = 14'd9000;

    // Speed scaling: 60 s * 32000 ticks/s << 4, and 360 degrees per turn.
    localparam logic [31:0] SPEED_SCALE = 32'd30720000;
    localparam logic [40:0] DEG_PER_TURN = 41'd360;

    // Shared divider geometry.
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 41;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 120;

    // Step direction indexed by (previous - current) mod 6.
    localparam logic signed [2:0] DIR_MAP [6] = '{3'sd0, -3'sd1, -3'sd2, 3'sd0, 3'sd2, 3'sd1};

    localparam logic signed [33:0] INT32_MAX_W = 34'sd2147483647;
    localparam logic signed [33:0] INT32_MIN_W = -34'sd2147483648;

    typedef struct packed {
        logic load;
        logic prep;
        logic decide;
        logic odo_start;
        logic odo_write;
        logic spd_start;
        logic spd_write;
        logic filt;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic odo_slow;
        logic meas_now;
        logic meas_pend;
        logic div_done;
        logic out_free;
    } sts_t;

    function automatic logic signed [2:0] step_dir(input logic [2:0] prev, input logic [2:0] cur);
        logic [3:0] d;
        logic [2:0] m6;
        begin
            d = {1'b0, prev} - {1'b0, cur};
            // d is a two's complement difference in -7..7; m6 is its floored residue.
            unique case (d)
                4'h0: m6 = 3'd0;
                4'h1: m6 = 3'd1;
                4'h2: m6 = 3'd2;
                4'h3: m6 = 3'd3;
                4'h4: m6 = 3'd4;
                4'h5: m6 = 3'd5;
                4'h6: m6 = 3'd0;
                4'h7: m6 = 3'd1;
                4'hF: m6 = 3'd5;
                4'hE: m6 = 3'd4;
                4'hD: m6 = 3'd3;
                4'hC: m6 = 3'd2;
                4'hB: m6 = 3'd1;
                4'hA: m6 = 3'd0;
                4'h9: m6 = 3'd5;
                default: m6 = 3'd0;
            endcase
            return DIR_MAP[m6];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        begin
            if (v > INT32_MAX_W) begin
                return 32'sh7FFFFFFF;
            end
            if (v < INT32_MIN_W) begin
                return 32'sh80000000;
            end
            return v[31:0];
        end
    endfunction

endpackage

### rtl/hse_div.sv
// Restoring divider, one quotient bit per cycle, shared by the odometer and the speed path.
module hse_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [hse_pkg::DIVIDEND_W-1:0]      dividend,
    input  logic [hse_pkg::DIVISOR_W-1:0]       divisor,
    output logic                                done,
    output logic [hse_pkg::DIVIDEND_W-1:0]      quotient,
    output logic [hse_pkg::DIVISOR_W-1:0]       remainder
);

    logic                               run_reg;
    logic                               done_reg;
    logic [hse_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [hse_pkg::DIVISOR_W-1:0]      rem_reg;
    logic [hse_pkg::DIVIDEND_W-1:0]     quo_reg;
    logic [hse_pkg::DIVISOR_W-1:0]      dvs_reg;

    logic [hse_pkg::DIVISOR_W:0]        trial;
    logic [hse_pkg::DIVISOR_W:0]        trial_sub;
    logic                               take;
    logic                               last;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[hse_pkg::DIVIDEND_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        take      = (trial >= {1'b0, dvs_reg});
        last      = (cnt_reg == hse_pkg::DIV_CNT_W'(hse_pkg::DIVIDEND_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            run_reg  <= !last;
            done_reg <= last;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= take ? trial_sub[hse_pkg::DIVISOR_W-1:0] : trial[hse_pkg::DIVISOR_W-1:0];
            quo_reg <= {quo_reg[hse_pkg::DIVIDEND_W-2:0], take};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### rtl/hse_dp.sv
// Datapath: configuration, odometry state, speed estimate, filter and output register.
module hse_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hse_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [hse_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [hse_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                m_tready,
    input  hse_pkg::cmd_t                       cmd,
    output hse_pkg::sts_t                       sts,
    output logic                                m_tvalid,
    output logic [hse_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser
);

    // Configuration.
    logic [15:0]        tmo_reg;
    logic [5:0]         thr_reg;
    logic [13:0]        mod_reg;

    // Estimator state.
    logic [2:0]         prev_pos_reg;
    logic [13:0]        odo_reg;
    logic [31:0]        angle_reg;
    logic signed [7:0]  dacc_reg;
    logic [31:0]        last_time_reg;
    logic               started_reg;
    logic signed [31:0] speed_last_reg;
    logic signed [31:0] smooth_reg;

    // Per-item working registers.
    logic [2:0]         pos_in_reg;
    logic [31:0]        now_reg;
    logic signed [2:0]  delta_reg;
    logic [31:0]        dt_reg;
    logic signed [7:0]  dsum_reg;
    logic [14:0]        odo_x_reg;
    logic               odo_slow_reg;
    logic               stop_reg;
    logic               meas_reg;
    logic [31:0]        num_reg;
    logic [40:0]        den_reg;
    logic               neg_reg;

    // Output register.
    logic                               out_valid_reg;
    logic [hse_pkg::OUT_DATA_W-1:0]     out_data_reg;
    logic                               out_stop_reg;

    // Divider interface.
    logic                               div_start;
    logic [hse_pkg::DIVIDEND_W-1:0]     div_dividend;
    logic [hse_pkg::DIVISOR_W-1:0]      div_divisor;
    logic                               div_done;
    logic [hse_pkg::DIVIDEND_W-1:0]     div_quo;
    logic [hse_pkg::DIVISOR_W-1:0]      div_rem;

    // Preparation step.
    logic signed [2:0]  delta_c;
    logic signed [4:0]  delta5;
    logic signed [4:0]  deg_c;
    logic signed [15:0] odo_sum;
    logic signed [15:0] mod_s;
    logic [13:0]        odo_fast;
    logic               slow_c;

    // Decision step.
    logic               stop_c;
    logic [7:0]         dmag;
    logic               trig_c;
    logic               meas_c;
    logic [31:0]        dtm;
    logic [31:0]        dtd;

    // Speed and filter.
    logic signed [33:0] spd_mag;
    logic signed [33:0] spd_val;
    logic signed [31:0] seed;
    logic signed [33:0] filt_sum;

    always_comb
    begin
        delta_c = hse_pkg::step_dir(prev_pos_reg, pos_in_reg);
        delta5  = {{2{delta_c[2]}}, delta_c};
        deg_c   = (delta5 <<< 2) + (delta5 <<< 1);
        odo_sum = $signed({2'b00, odo_reg}) + {{13{delta_c[2]}}, delta_c};
        mod_s   = $signed({2'b00, mod_reg});

        // A modulus below two clears the count; with the count in range, one
        // correction step is enough; otherwise the divider reduces the sum.
        slow_c   = 1'b0;
        odo_fast = '0;
        if (mod_reg < 14'd2)
        begin
            odo_fast = '0;
        end
        else if (odo_reg < mod_reg)
        begin
            if (odo_sum < 16'sd0)
            begin
                odo_fast = 14'(odo_sum + mod_s);
            end
            else if (odo_sum >= mod_s)
            begin
                odo_fast = 14'(odo_sum - mod_s);
            end
            else
            begin
                odo_fast = odo_sum[13:0];
            end
        end
        else
        begin
            slow_c = 1'b1;
        end
    end

    always_comb
    begin
        stop_c = started_reg && ($signed(dt_reg) > $signed({16'h0000, tmo_reg}));
        dmag   = dsum_reg[7] ? 8'(-dsum_reg) : 8'(dsum_reg);
        trig_c = dmag >= {2'b00, thr_reg};
        meas_c = !stop_c && trig_c && started_reg;
        dtm    = dt_reg[31] ? (~dt_reg + 32'd1) : dt_reg;
        dtd    = (dtm == 32'd0) ? 32'd1 : dtm;
    end

    always_comb
    begin
        div_start    = cmd.odo_start || cmd.spd_start;
        div_dividend = cmd.spd_start ? num_reg : {17'b0, odo_x_reg};
        div_divisor  = cmd.spd_start ? den_reg : {27'b0, mod_reg};
    end

    always_comb
    begin
        // The quotient stays below 2^24, so the shifted magnitude fits easily.
        spd_mag  = $signed({div_quo[29:0], 4'b0000});
        spd_val  = neg_reg ? -spd_mag : spd_mag;
        seed     = (smooth_reg == 32'sd0) ? speed_last_reg : smooth_reg;
        filt_sum = 34'(seed) - 34'(seed >>> 5) + 34'(speed_last_reg >>> 5);
    end

    hse_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_reg        <= hse_pkg::STOP_TIMEOUT_RST;
            thr_reg        <= hse_pkg::STEP_THRESH_RST;
            mod_reg        <= hse_pkg::ODO_MODULUS_RST;
            prev_pos_reg   <= '0;
            odo_reg        <= '0;
            angle_reg      <= '0;
            dacc_reg       <= '0;
            last_time_reg  <= '0;
            started_reg    <= 1'b0;
            speed_last_reg <= '0;
            smooth_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    hse_pkg::CFG_STOP_TIMEOUT: tmo_reg <= cfg_wdata;
                    hse_pkg::CFG_STEP_THRESH:  thr_reg <= cfg_wdata[5:0];
                    hse_pkg::CFG_ODO_MODULUS:  mod_reg <= cfg_wdata[13:0];
                    default: ;
                endcase
            end

            if (cmd.prep)
            begin
                prev_pos_reg <= pos_in_reg;
                angle_reg    <= angle_reg + {{27{deg_c[4]}}, deg_c};
                if (!slow_c)
                begin
                    odo_reg <= odo_fast;
                end
            end
            else if (cmd.odo_write)
            begin
                odo_reg <= div_rem[13:0];
            end

            if (cmd.decide)
            begin
                if (stop_c)
                begin
                    last_time_reg <= '0;
                    started_reg   <= 1'b0;
                end
                else
                begin
                    dacc_reg <= trig_c ? 8'sd0 : dsum_reg;
                    if (trig_c)
                    begin
                        last_time_reg <= now_reg;
                        started_reg   <= 1'b1;
                    end
                end
            end

            if (cmd.decide && stop_c)
            begin
                speed_last_reg <= '0;
                smooth_reg     <= '0;
            end
            else if (cmd.spd_write)
            begin
                speed_last_reg <= hse_pkg::sat32(spd_val);
            end
            else if (cmd.filt)
            begin
                smooth_reg <= hse_pkg::sat32(filt_sum);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_in_reg <= s_tdata[2:0];
            now_reg    <= s_tdata[34:3];
        end

        if (cmd.prep)
        begin
            delta_reg    <= delta_c;
            dt_reg       <= now_reg - last_time_reg;
            dsum_reg     <= dacc_reg + {{3{deg_c[4]}}, deg_c};
            odo_x_reg    <= odo_sum[14:0];
            odo_slow_reg <= slow_c;
        end

        if (cmd.decide)
        begin
            stop_reg <= stop_c;
            meas_reg <= meas_c;
            num_reg  <= 32'(dmag[6:0]) * hse_pkg::SPEED_SCALE;
            den_reg  <= 41'(dtd) * hse_pkg::DEG_PER_TURN;
            neg_reg  <= dsum_reg[7] ^ dt_reg[31];
        end

        if (cmd.out_load)
        begin
            out_data_reg <= {7'b0, smooth_reg, speed_last_reg, angle_reg, odo_reg, delta_reg};
            out_stop_reg <= stop_reg;
        end
    end

    always_comb
    begin
        sts.odo_slow  = odo_slow_reg;
        sts.meas_now  = meas_c;
        sts.meas_pend = meas_reg;
        sts.div_done  = div_done;
        sts.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_stop_reg;

endmodule

### rtl/hse_ctrl.sv
// Controller: sequences one item through preparation, decision, optional division and filter, and output.
module hse_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  hse_pkg::sts_t   sts,
    output logic            s_tready,
    output hse_pkg::cmd_t   cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_PREP     = 4'd1;
    localparam logic [3:0] ST_DECIDE   = 4'd2;
    localparam logic [3:0] ST_ODO_GO   = 4'd3;
    localparam logic [3:0] ST_ODO_WAIT = 4'd4;
    localparam logic [3:0] ST_SPD_GO   = 4'd5;
    localparam logic [3:0] ST_SPD_WAIT = 4'd6;
    localparam logic [3:0] ST_FILT     = 4'd7;
    localparam logic [3:0] ST_OUT      = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                priority if (sts.odo_slow)
                begin
                    state_next = ST_ODO_GO;
                end
                else if (sts.meas_now)
                begin
                    state_next = ST_SPD_GO;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_ODO_GO:
            begin
                cmd.odo_start = 1'b1;
                state_next    = ST_ODO_WAIT;
            end
            ST_ODO_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.odo_write = 1'b1;
                    state_next    = sts.meas_pend ? ST_SPD_GO : ST_OUT;
                end
            end
            ST_SPD_GO:
            begin
                cmd.spd_start = 1'b1;
                state_next    = ST_SPD_WAIT;
            end
            ST_SPD_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.spd_write = 1'b1;
                    state_next    = ST_FILT;
                end
            end
            ST_FILT:
            begin
                cmd.filt   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/hall_odometry_speed_estimator.sv
// Top level of the hall odometry and speed estimator.
//
//  Channel   Signals                            Content (lowest bit first)
//  input     s_tvalid s_tready s_tdata[39:0]    hall_position[2:0], timestamp[34:3]
//  result    m_tvalid m_tready m_tdata[119:0]   step_delta, odometer, wheel_angle_deg,
//            m_tuser                            speed_raw, speed_filtered; tuser = stopped
//  config    cfg_we cfg_addr cfg_wdata          0 stop timeout, 1 step threshold, 2 modulus
//
// An item passes preparation, decision and output when no speed measurement is due,
// and also the 32-step shared divider and the filter when one is. After the odometer
// modulus is lowered below the count, the next item passes through that divider too.
// The input is taken only while the controller is idle; a full output register that is
// not drained stalls the controller before it loads the next result. Reset is immediate.
module hall_odometry_speed_estimator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hse_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [hse_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // hall_position[2:0], timestamp[34:3], zero fill above
    input  logic [hse_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // step_delta[2:0], odometer[16:3], wheel_angle_deg[48:17],
    // speed_raw[80:49], speed_filtered[112:81], zero fill above
    output logic [hse_pkg::OUT_DATA_W-1:0]      m_tdata,
    // stopped[0]
    output logic                                m_tuser
);

    hse_pkg::cmd_t cmd;
    hse_pkg::sts_t sts;

    hse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    hse_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### rtl/hse_check.sv
// Port-level checker for the hall odometry and speed estimator, bound to the top level.
module hse_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [hse_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                m_tuser
);

    // One item at a time: after an input transfer the block is busy for a while.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again right after a transfer");

    // A stopped result carries zero raw and filtered speed.
    a_stop_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[112:49] == 64'd0))
        else $error("stopped result with nonzero speed");

    // Step delta is never below -2.
    a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[2:0] != 3'b100) && (m_tdata[2:0] != 3'b101)))
        else $error("step delta out of range");

    // The odometer never reaches the largest 14-bit value.
    a_odo_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:3] != 14'h3FFF))
        else $error("odometer out of range");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind hall_odometry_speed_estimator hse_check u_hse_check (.*);

### tb/hall_odometry_speed_estimator_tb.sv
// Self-checking testbench for the hall odometry and speed estimator.
module hall_odometry_speed_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The slowest item passes the shared divider twice, plus random stalls on both sides.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam longint RPM_SCALE = 64'sd30720000;

    typedef struct packed {
        logic signed [2:0]  step_delta;
        logic [13:0]        odometer;
        logic signed [31:0] wheel_angle_deg;
        logic signed [31:0] speed_raw;
        logic signed [31:0] speed_filtered;
        logic               stopped;
    } hall_reading_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [hse_pkg::CFG_ADDR_W-1:0]   cfg_addr = '0;
    logic [hse_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [hse_pkg::IN_DATA_W-1:0]    s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [hse_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                             m_tuser;

    // Copy of the configuration as the block holds it.
    logic [15:0] cfg_timeout = hse_pkg::STOP_TIMEOUT_RST;
    logic [5:0]  cfg_thresh  = hse_pkg::STEP_THRESH_RST;
    logic [13:0] cfg_modulus = hse_pkg::ODO_MODULUS_RST;

    // Estimator state as predicted.
    logic [2:0]         prev_pos = '0;
    logic [13:0]        odo_count = '0;
    logic [31:0]        angle_acc = '0;
    int                 deg_acc = 0;
    logic [31:0]        capture_stamp = '0;
    bit                 capture_armed = 1'b0;
    logic signed [31:0] speed_meas = '0;
    logic signed [31:0] speed_smooth = '0;

    hall_reading_t readings_due[$];
    int            fail_count = 0;
    int            quiet_cycles = 0;
    bit            gaps_on = 1'b1;

    hall_odometry_speed_estimator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 clk = ~clk;

    function automatic logic signed [31:0] clamp_int32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Updates the predicted state with one input and returns the reading it yields.
    function automatic hall_reading_t advance_estimator(input logic [2:0] pos,
                                                        input logic [31:0] stamp);
        hall_reading_t     r;
        int                residue;
        int                delta;
        int                deg;
        int                wrapped;
        int                mag;
        logic signed [31:0] dt;
        longint            divisor;
        longint            rate;
        longint            blended;
        logic              stop;
        begin
            stop = 1'b0;
            residue = (int'(prev_pos) - int'(pos)) % 6;
            if (residue < 0)
            begin
                residue += 6;
            end
            case (residue)
                1: delta = -1;
                2: delta = -2;
                4: delta = 2;
                5: delta = 1;
                default: delta = 0;
            endcase
            prev_pos = pos;

            if (cfg_modulus == 0)
            begin
                odo_count = '0;
            end
            else
            begin
                wrapped = (int'(odo_count) + delta) % int'(cfg_modulus);
                if (wrapped < 0)
                begin
                    wrapped += int'(cfg_modulus);
                end
                odo_count = wrapped[13:0];
            end

            deg = delta * 6;
            angle_acc = angle_acc + 32'(deg);
            dt = $signed(stamp - capture_stamp);

            if (capture_armed && int'(dt) > int'(cfg_timeout))
            begin
                // Rotation timed out: the estimator starts over, degrees are kept.
                speed_meas = '0;
                speed_smooth = '0;
                capture_stamp = '0;
                capture_armed = 1'b0;
                stop = 1'b1;
            end
            else
            begin
                deg_acc += deg;
                mag = (deg_acc < 0) ? -deg_acc : deg_acc;
                if (mag >= int'(cfg_thresh))
                begin
                    if (!capture_armed)
                    begin
                        capture_stamp = stamp;
                        capture_armed = 1'b1;
                    end
                    else
                    begin
                        divisor = (dt == 0) ? 64'sd1 : longint'(dt);
                        rate = (longint'(deg_acc) * RPM_SCALE) / divisor / 360;
                        speed_meas = clamp_int32(rate * 16);
                        if (speed_smooth == 0)
                        begin
                            speed_smooth = speed_meas;
                        end
                        blended = longint'(speed_smooth) - (longint'(speed_smooth) >>> 5)
                                  + (longint'(speed_meas) >>> 5);
                        speed_smooth = clamp_int32(blended);
                        capture_stamp = stamp;
                    end
                    deg_acc = 0;
                end
            end

            r.step_delta = 3'(delta);
            r.odometer = odo_count;
            r.wheel_angle_deg = angle_acc;
            r.speed_raw = speed_meas;
            r.speed_filtered = speed_smooth;
            r.stopped = stop;
            return r;
        end
    endfunction

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Result side: random backpressure and comparison against the oldest prediction.
    always @(posedge clk)
    begin : check_readings
        hall_reading_t want;
        m_tready <= !gaps_on || ($urandom_range(99) >= 31);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (readings_due.size() == 0)
            begin
                $error("result transfer with no reading pending");
                fail_count++;
            end
            else
            begin
                want = readings_due.pop_front();
                check_field("step_delta", $signed(want.step_delta), $signed(m_tdata[2:0]));
                check_field("odometer", want.odometer, m_tdata[16:3]);
                check_field("wheel_angle_deg", $signed(want.wheel_angle_deg),
                            $signed(m_tdata[48:17]));
                check_field("speed_raw", $signed(want.speed_raw), $signed(m_tdata[80:49]));
                check_field("speed_filtered", $signed(want.speed_filtered),
                            $signed(m_tdata[112:81]));
                check_field("stopped", want.stopped, m_tuser);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_reading(input logic [2:0] pos, input logic [31:0] stamp);
        while (gaps_on && $urandom_range(99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, stamp, pos};
        do
            @(posedge clk);
        while (!s_tready);
        readings_due.push_back(advance_estimator(pos, stamp));
    endtask

    // Moves the hall position by d sectors from the last one sent.
    task automatic turn(input int d, input logic [31:0] stamp);
        send_reading(3'((int'(prev_pos) + d + 6) % 6), stamp);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (readings_due.size() != 0 || !s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [hse_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            hse_pkg::CFG_STOP_TIMEOUT: cfg_timeout = value;
            hse_pkg::CFG_STEP_THRESH:  cfg_thresh = value[5:0];
            hse_pkg::CFG_ODO_MODULUS:  cfg_modulus = value[13:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] timeout, input logic [15:0] thresh,
                             input logic [15:0] modulus);
        drain_results();
        write_reg(hse_pkg::CFG_STOP_TIMEOUT, timeout);
        write_reg(hse_pkg::CFG_STEP_THRESH, thresh);
        write_reg(hse_pkg::CFG_ODO_MODULUS, modulus);
    endtask

    // Every residue of the sector difference, sectors six and seven, timestamp extremes.
    task automatic test_sector_steps();
        send_reading(3'd0, 32'd0);
        send_reading(3'd1, 32'd10);
        send_reading(3'd3, 32'd20);
        send_reading(3'd2, 32'd30);
        send_reading(3'd0, 32'd40);
        send_reading(3'd5, 32'd50);
        send_reading(3'd4, 32'd60);
        send_reading(3'd6, 32'd70);
        send_reading(3'd7, 32'd80);
        send_reading(3'd0, 32'd90);
        send_reading(3'd3, 32'hFFFF_FFFF);
    endtask

    // First capture, a normal measurement, zero and negative elapsed time, zero threshold.
    task automatic test_speed_measurement();
        configure(16'd65535, 16'd6, 16'd7);
        turn(1, 32'd5000);
        turn(1, 32'd5040);
        turn(1, 32'd5040);
        turn(-1, 32'd5030);
        configure(16'd65535, 16'd0, 16'd16383);
        turn(0, 32'd5100);
    endtask

    // Timeout after a measurement, re-arming, and elapsed time across the counter wrap.
    task automatic test_stop_timeout();
        configure(16'd100, 16'd6, 16'd9000);
        turn(1, 32'd1000);
        turn(1, 32'd1050);
        turn(1, 32'd1151);
        configure(16'd1, 16'd6, 16'd9000);
        turn(1, 32'hFFFF_FFFF);
        turn(1, 32'd0);
        turn(1, 32'd2);
    endtask

    // Odometer at its top value, a lowered modulus and a zero modulus.
    task automatic test_odometer_modulus();
        configure(16'd65535, 16'd63, 16'd1);
        turn(1, 32'd300);
        configure(16'd65535, 16'd63, 16'd16383);
        turn(-1, 32'd310);
        configure(16'd65535, 16'd63, 16'd5);
        turn(2, 32'd320);
        configure(16'd65535, 16'd63, 16'd0);
        turn(1, 32'd330);
    endtask

    task automatic test_random_rotation(input int total);
        int          sent;
        int          phase;
        int          phase_len;
        int          dir;
        int          d;
        int          dt;
        int          span;
        int          pick;
        logic [15:0] timeout;
        logic [15:0] thresh;
        logic [15:0] modulus;
        logic [31:0] stamp;
        begin
            sent = 0;
            phase = 0;
            while (sent < total)
            begin
                case (phase % 8)
                    1:
                    begin
                        timeout = 16'd65535;
                        thresh = 16'd63;
                        modulus = 16'd16383;
                    end
                    3:
                    begin
                        timeout = 16'd1;
                        thresh = 16'd1;
                        modulus = 16'd1;
                    end
                    5:
                    begin
                        timeout = 16'd0;
                        thresh = 16'd0;
                        modulus = 16'd0;
                    end
                    default:
                    begin
                        timeout = 16'($urandom_range(20, 4000));
                        thresh = 16'($urandom_range(1, 63));
                        modulus = 16'($urandom_range(2, 16383));
                    end
                endcase
                configure(timeout, thresh, modulus);
                // One phase runs with both sides always ready.
                gaps_on = (phase != 2);
                phase_len = $urandom_range(50, 100);
                dir = ($urandom_range(1) == 1) ? 1 : -1;
                span = (int'(timeout) / 8 > 1) ? int'(timeout) / 8 : 1;
                stamp = $urandom;
                for (int i = 0; i < phase_len && sent < total; i++)
                begin
                    if (i == phase_len / 2 && phase % 3 == 0)
                    begin
                        drain_results();
                    end
                    pick = $urandom_range(99);
                    if (pick < 80)
                    begin
                        pick = $urandom_range(99);
                        if (pick < 60) d = dir;
                        else if (pick < 75) d = 2 * dir;
                        else if (pick < 85) d = 0;
                        else d = -dir;
                        pick = $urandom_range(99);
                        if (pick < 85) dt = $urandom_range(0, span);
                        else if (pick < 92) dt = int'(timeout) + $urandom_range(1, 1000);
                        else if (pick < 96) dt = 0;
                        else dt = -$urandom_range(1, 50);
                        stamp = stamp + 32'(dt);
                        turn(d, stamp);
                    end
                    else
                    begin
                        send_reading(3'($urandom_range(7)), $urandom);
                    end
                    sent++;
                end
                phase++;
            end
            gaps_on = 1'b1;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_sector_steps();
        test_speed_measurement();
        test_stop_timeout();
        test_odometer_modulus();
        test_random_rotation(625);
        drain_results();
        repeat (80) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
